### rtl/r2y420_pkg.sv
// Shared constants for the RGB to YUV 4:2:0 planar converter.
// Used by r2y420_csc and rgb_to_yuv420_planar; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package r2y420_pkg;

  // field and register widths
  localparam int unsigned COMP_W  = 8;
  localparam int unsigned IDX_W   = 24;
  localparam int unsigned CIDX_W  = 22;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // frame geometry defaults
  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;
  localparam int unsigned RST_WIDTH      = 640;
  localparam int unsigned RST_HEIGHT     = 480;
  localparam int unsigned MIN_WIDTH      = 2;

  // chroma planes
  localparam logic PLANE_CB = 1'b0;
  localparam logic PLANE_CR = 1'b1;

  // BT.601 studio-range coefficients (8 fractional bits)
  localparam int unsigned Y_R = 66;
  localparam int unsigned Y_G = 129;
  localparam int unsigned Y_B = 25;
  localparam int unsigned Y_OFS = 16;
  localparam int unsigned RND = 128;
  // chroma: offset 128 folded in as 128 << 8, negative terms by magnitude
  localparam int unsigned C_BIAS  = 32768;
  localparam int unsigned CB_R_NEG = 38;
  localparam int unsigned CB_G_NEG = 74;
  localparam int unsigned CB_B     = 112;
  localparam int unsigned CR_R     = 112;
  localparam int unsigned CR_G_NEG = 94;
  localparam int unsigned CR_B_NEG = 18;

endpackage

`default_nettype wire

### rtl/r2y420_csc.sv
// Color space conversion: one RGB pixel to luma and one chroma sample.
// Pure combinational; depends on r2y420_pkg.
`timescale 1ns / 1ps
`default_nettype none

module r2y420_csc (
  input  wire logic [r2y420_pkg::COMP_W-1:0] red_i,
  input  wire logic [r2y420_pkg::COMP_W-1:0] green_i,
  input  wire logic [r2y420_pkg::COMP_W-1:0] blue_i,
  input  wire logic                          plane_i,
  output logic      [r2y420_pkg::COMP_W-1:0] luma_o,
  output logic      [r2y420_pkg::COMP_W-1:0] chroma_o
);

  logic [15:0] y_sum;
  logic [16:0] cb_sum;
  logic [16:0] cr_sum;

  // max 56228, fits 16 bits
  assign y_sum = 16'(r2y420_pkg::Y_R * red_i) + 16'(r2y420_pkg::Y_G * green_i)
               + 16'(r2y420_pkg::Y_B * blue_i) + 16'(r2y420_pkg::RND);
  assign luma_o = y_sum[15:8] + 8'(r2y420_pkg::Y_OFS);

  // biased sums land in 0..65535; modular 17-bit math is exact there
  assign cb_sum = 17'(r2y420_pkg::CB_B * blue_i)
                + 17'(r2y420_pkg::RND + r2y420_pkg::C_BIAS)
                - 17'(r2y420_pkg::CB_R_NEG * red_i)
                - 17'(r2y420_pkg::CB_G_NEG * green_i);
  assign cr_sum = 17'(r2y420_pkg::CR_R * red_i)
                + 17'(r2y420_pkg::RND + r2y420_pkg::C_BIAS)
                - 17'(r2y420_pkg::CR_G_NEG * green_i)
                - 17'(r2y420_pkg::CR_B_NEG * blue_i);

  assign chroma_o = (plane_i == r2y420_pkg::PLANE_CR) ? cr_sum[15:8] : cb_sum[15:8];

endmodule

`default_nettype wire

### rtl/rgb_to_yuv420_planar.sv
// RGB to YUV 4:2:0 planar converter, top level.
// Depends on r2y420_pkg and r2y420_csc.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one RGB word per cycle in
//   raster order. Output channel (out_valid_o/out_ready_i) gives one word per
//   pixel: luma and its plane index, plus a Cb sample on even rows or a Cr
//   sample on odd rows at even columns, and frame_last on the final pixel.
//   Output valid rises in the cycle after input accept. The converter takes
//   one pixel per clock unless the receiver stalls; the conversion math is
//   combinational between the input port and the output register.
//   The output register is the only buffer: a new word is accepted while the
//   held one is taken in the same cycle. When the receiver stalls, the
//   result holds and in_ready_o drops until it is taken.
//   Reset clears the column, row and index counters and loads 640x480.
//   A write to frame_width or frame_height clamps to the supported range and
//   restarts the frame; only write while idle, the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_yuv420_planar #(
  parameter int unsigned MAX_WIDTH  = r2y420_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = r2y420_pkg::DEF_MAX_HEIGHT
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration
  input  wire logic                             cfg_we_i,
  input  wire logic [r2y420_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [r2y420_pkg::CFG_W-1:0]     cfg_data_i,
  // pixel input
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [r2y420_pkg::COMP_W-1:0]    red_i,
  input  wire logic [r2y420_pkg::COMP_W-1:0]    green_i,
  input  wire logic [r2y420_pkg::COMP_W-1:0]    blue_i,
  // sample output
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [r2y420_pkg::COMP_W-1:0]    luma_o,
  output logic      [r2y420_pkg::IDX_W-1:0]     luma_index_o,
  output logic                                  chroma_valid_o,
  output logic                                  chroma_plane_o,
  output logic      [r2y420_pkg::COMP_W-1:0]    chroma_value_o,
  output logic      [r2y420_pkg::CIDX_W-1:0]    chroma_index_o,
  output logic                                  frame_last_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned HALF_W = WW - 1;
  localparam int unsigned CMP_W = r2y420_pkg::CFG_W + 1;

  localparam logic [WW-1:0] W_RST = WW'((r2y420_pkg::RST_WIDTH > MAX_WIDTH) ?
                                        MAX_WIDTH : r2y420_pkg::RST_WIDTH);
  localparam logic [HW-1:0] H_RST = HW'((r2y420_pkg::RST_HEIGHT > MAX_HEIGHT) ?
                                        MAX_HEIGHT : r2y420_pkg::RST_HEIGHT);

  // clamped geometry
  logic [WW-1:0] width_q, width_d;
  logic [HW-1:0] height_q, height_d;
  logic          restart;

  // position state
  logic [COL_W-1:0]              col_q, col_d;
  logic [ROW_W-1:0]              row_q, row_d;
  logic [r2y420_pkg::IDX_W-1:0]  pix_q, pix_d;
  logic [r2y420_pkg::CIDX_W-1:0] cbase_q, cbase_d;  // half * (row / 2)

  // output register
  logic                          out_valid_q;
  logic [r2y420_pkg::COMP_W-1:0] luma_q;
  logic [r2y420_pkg::IDX_W-1:0]  luma_index_q;
  logic                          chroma_valid_q;
  logic                          chroma_plane_q;
  logic [r2y420_pkg::COMP_W-1:0] chroma_value_q;
  logic [r2y420_pkg::CIDX_W-1:0] chroma_index_q;
  logic                          frame_last_q;

  logic                          in_fire;
  logic [HALF_W-1:0]             half;
  logic [HALF_W-1:0]             hcol;
  logic [HALF_W-1:0]             hcol_fold;
  logic                          row_end;
  logic                          last;
  logic                          cvalid;
  logic [r2y420_pkg::COMP_W-1:0] luma_c;
  logic [r2y420_pkg::COMP_W-1:0] chroma_c;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // ---------------- configuration ----------------
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    restart  = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        r2y420_pkg::REG_FRAME_WIDTH: begin
          restart = 1'b1;
          if (cfg_data_i < r2y420_pkg::CFG_W'(r2y420_pkg::MIN_WIDTH)) begin
            width_d = WW'(r2y420_pkg::MIN_WIDTH);
          end else if ({1'b0, cfg_data_i} > CMP_W'(MAX_WIDTH)) begin
            width_d = WW'(MAX_WIDTH);
          end else begin
            width_d = WW'(cfg_data_i);
          end
        end
        r2y420_pkg::REG_FRAME_HEIGHT: begin
          restart = 1'b1;
          if (cfg_data_i == '0) begin
            height_d = HW'(1);
          end else if ({1'b0, cfg_data_i} > CMP_W'(MAX_HEIGHT)) begin
            height_d = HW'(MAX_HEIGHT);
          end else begin
            height_d = HW'(cfg_data_i);
          end
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= W_RST;
      height_q <= H_RST;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // ---------------- position tracking ----------------
  assign half      = width_q[WW-1:1];
  assign hcol      = HALF_W'(col_q >> 1);
  // odd width: last column folds onto chroma index 0
  assign hcol_fold = (hcol == half) ? '0 : hcol;
  assign row_end   = (WW'(col_q) + WW'(1)) >= width_q;
  assign last      = row_end && ((HW'(row_q) + HW'(1)) >= height_q);
  assign cvalid    = !col_q[0];

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    pix_d   = pix_q;
    cbase_d = cbase_q;
    if (restart) begin
      col_d   = '0;
      row_d   = '0;
      pix_d   = '0;
      cbase_d = '0;
    end else if (in_fire) begin
      if (last) begin
        col_d   = '0;
        row_d   = '0;
        pix_d   = '0;
        cbase_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
        pix_d = pix_q + r2y420_pkg::IDX_W'(1);
        // leaving an odd row starts the next chroma row
        if (row_q[0]) begin
          cbase_d = cbase_q + r2y420_pkg::CIDX_W'(half);
        end
      end else begin
        col_d = col_q + COL_W'(1);
        pix_d = pix_q + r2y420_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      pix_q   <= '0;
      cbase_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      pix_q   <= pix_d;
      cbase_q <= cbase_d;
    end
  end

  // ---------------- conversion ----------------
  r2y420_csc u_csc (
    .red_i    (red_i),
    .green_i  (green_i),
    .blue_i   (blue_i),
    .plane_i  (row_q[0]),
    .luma_o   (luma_c),
    .chroma_o (chroma_c)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      luma_q         <= luma_c;
      luma_index_q   <= pix_q;
      chroma_valid_q <= cvalid;
      chroma_plane_q <= cvalid ? row_q[0] : r2y420_pkg::PLANE_CB;
      chroma_value_q <= cvalid ? chroma_c : '0;
      chroma_index_q <= cvalid ? (cbase_q + r2y420_pkg::CIDX_W'(hcol_fold)) : '0;
      frame_last_q   <= last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign luma_o         = luma_q;
  assign luma_index_o   = luma_index_q;
  assign chroma_valid_o = chroma_valid_q;
  assign chroma_plane_o = chroma_plane_q;
  assign chroma_value_o = chroma_value_q;
  assign chroma_index_o = chroma_index_q;
  assign frame_last_o   = frame_last_q;

endmodule

`default_nettype wire
